// ===== hw/rtl/ffea_pkg.sv =====
// Shared types and constants for the first-fit extent allocator.
// Holds table entry layout, status codes and controller/datapath command types.
// No dependencies.
package ffea_pkg;

	localparam int unsigned OFF_W = 48;
	localparam int unsigned LEN_W = 49;
	// Growth target: starts at 65536 when nothing is claimed, else 2*claimed (< 2^50),
	// and only doubles while short of a 48-bit request, so it stays below 2^51.
	localparam int unsigned NT_W = 52;
	localparam int unsigned MAX_FREE_EXTENTS_DEF = 64;
	localparam logic [NT_W-1:0] FIRST_CLAIM = NT_W'(65536);

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_CAPACITY = 2'd1,
		ST_FULL     = 2'd2,
		ST_OVERLAP  = 2'd3
	} status_t;

	typedef struct packed {
		logic [OFF_W-1:0] start;
		logic [LEN_W-1:0] len;
	} ext_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_RD_IDX,
		OP_RD_K1,
		OP_RD_KM1,
		OP_RD_TAIL,
		OP_SCAN_NEXT,
		OP_MARK_NEXT,
		OP_FIT,
		OP_GROW_INIT,
		OP_GROW_DBL,
		OP_EXTEND,
		OP_APPEND,
		OP_SHIFT_UP,
		OP_DEC,
		OP_INS_SETUP,
		OP_SHIFT_DN,
		OP_INS_PUT,
		OP_MERGE_PREV,
		OP_MERGE_NEXT,
		OP_SET_STATUS,
		OP_DONE
	} dp_op_t;

	typedef struct packed {
		dp_op_t  op;
		status_t code;
	} cmd_t;

	typedef struct packed {
		logic kind_free;
		logic size_zero;
		logic idx_end;
		logic fits;
		logic exact;
		logic grown;
		logic grow_short;
		logic over_cap;
		logic count_zero;
		logic full;
		logic tail_adj;
		logic gt_off;
		logic ovl;
		logic mprev;
		logic mnext;
		logic k_more;
		logic k_above;
	} sts_t;

endpackage

// ===== hw/rtl/ffea_dp.sv =====
// Datapath of the extent allocator: extent table memory, scan/shift pointers,
// growth arithmetic and result registers. Driven by ffea_ctrl; uses ffea_pkg.
module ffea_dp #(
	parameter int unsigned MaxExt = ffea_pkg::MAX_FREE_EXTENTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ffea_pkg::LEN_W-1:0]    cfg_wdata,
	input  logic                          kind,
	input  logic [ffea_pkg::OFF_W-1:0]    extent_offset,
	input  logic [ffea_pkg::OFF_W-1:0]    extent_bytes,
	input  ffea_pkg::cmd_t                cmd,
	output ffea_pkg::sts_t                sts,
	output logic                          done,
	output logic [ffea_pkg::OFF_W-1:0]    granted_offset,
	output logic [1:0]                    status,
	output logic [ffea_pkg::LEN_W-1:0]    claimed_total
);

	localparam int unsigned CW = $clog2(MaxExt + 1);
	localparam int unsigned AW = $clog2(MaxExt);
	localparam logic [CW-1:0] MAX_CNT = CW'(MaxExt);

	ffea_pkg::ext_t mem [MaxExt];
	ffea_pkg::ext_t rdata_q, prev_q, wdata_c;

	logic [CW-1:0] count_q, idx_q, k_q, raddr_c, waddr_c;
	logic          rd_en_c, we_c;

	logic                          kind_q, grown_q, has_next_q, done_q;
	logic [ffea_pkg::OFF_W-1:0]    off_q, size_q, granted_q;
	logic [ffea_pkg::LEN_W-1:0]    claimed_q, cap_q;
	logic [ffea_pkg::NT_W-1:0]     nt_q;
	ffea_pkg::status_t             status_q;

	logic [ffea_pkg::LEN_W-1:0]    end_c, delta_c, mlen_c;
	logic [ffea_pkg::LEN_W:0]      prev_end_c, tail_end_c;
	logic [ffea_pkg::NT_W-1:0]     gap_c;
	logic [CW:0]                   k1_c;

	// request-derived arithmetic
	assign end_c      = {1'b0, off_q} + {1'b0, size_q};
	assign prev_end_c = {2'b0, prev_q.start} + {1'b0, prev_q.len};
	assign tail_end_c = {2'b0, rdata_q.start} + {1'b0, rdata_q.len};
	assign gap_c      = nt_q - {3'b0, claimed_q};
	assign delta_c    = gap_c[ffea_pkg::LEN_W-1:0];
	assign mlen_c     = prev_q.len + {1'b0, size_q}
		+ ((has_next_q && (end_c == {1'b0, rdata_q.start})) ? rdata_q.len : '0);
	assign k1_c       = {1'b0, k_q} + 1'b1;

	always_comb begin
		sts.kind_free  = kind_q;
		sts.size_zero  = (size_q == '0);
		sts.idx_end    = (idx_q >= count_q);
		sts.fits       = (rdata_q.len >= {1'b0, size_q});
		sts.exact      = (rdata_q.len == {1'b0, size_q});
		sts.grown      = grown_q;
		sts.grow_short = (gap_c < {4'b0, size_q});
		sts.over_cap   = (nt_q > {3'b0, cap_q});
		sts.count_zero = (count_q == '0);
		sts.full       = (count_q >= MAX_CNT);
		sts.tail_adj   = (tail_end_c == {1'b0, claimed_q});
		sts.gt_off     = (rdata_q.start > off_q);
		sts.ovl        = ((idx_q != '0) && ({2'b0, off_q} < prev_end_c))
			|| (has_next_q && (end_c > {1'b0, rdata_q.start}));
		sts.mprev      = (idx_q != '0) && ({2'b0, off_q} == prev_end_c);
		sts.mnext      = has_next_q && (end_c == {1'b0, rdata_q.start});
		sts.k_more     = (k1_c < {1'b0, count_q});
		sts.k_above    = (k_q > idx_q);
	end

	// memory port selection
	always_comb begin
		rd_en_c = 1'b0;
		raddr_c = idx_q;
		we_c    = 1'b0;
		waddr_c = idx_q;
		wdata_c = rdata_q;
		case (cmd.op)
			ffea_pkg::OP_RD_IDX: rd_en_c = 1'b1;
			ffea_pkg::OP_RD_K1: begin
				rd_en_c = 1'b1;
				raddr_c = k1_c[CW-1:0];
			end
			ffea_pkg::OP_RD_KM1: begin
				rd_en_c = 1'b1;
				raddr_c = k_q - 1'b1;
			end
			ffea_pkg::OP_RD_TAIL: begin
				rd_en_c = 1'b1;
				raddr_c = count_q - 1'b1;
			end
			ffea_pkg::OP_FIT: begin
				we_c          = !sts.exact;
				wdata_c.start = rdata_q.start + size_q;
				wdata_c.len   = rdata_q.len - {1'b0, size_q};
			end
			ffea_pkg::OP_SHIFT_UP, ffea_pkg::OP_SHIFT_DN: begin
				we_c    = 1'b1;
				waddr_c = k_q;
			end
			ffea_pkg::OP_EXTEND: begin
				we_c        = 1'b1;
				waddr_c     = count_q - 1'b1;
				wdata_c.len = rdata_q.len + delta_c;
			end
			ffea_pkg::OP_APPEND: begin
				we_c          = 1'b1;
				waddr_c       = count_q;
				wdata_c.start = claimed_q[ffea_pkg::OFF_W-1:0];
				wdata_c.len   = delta_c;
			end
			ffea_pkg::OP_MERGE_PREV: begin
				we_c          = 1'b1;
				waddr_c       = idx_q - 1'b1;
				wdata_c.start = prev_q.start;
				wdata_c.len   = mlen_c;
			end
			ffea_pkg::OP_MERGE_NEXT: begin
				we_c          = 1'b1;
				wdata_c.start = off_q;
				wdata_c.len   = rdata_q.len + {1'b0, size_q};
			end
			ffea_pkg::OP_INS_PUT: begin
				we_c          = 1'b1;
				wdata_c.start = off_q;
				wdata_c.len   = {1'b0, size_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_c) begin
			mem[waddr_c[AW-1:0]] <= wdata_c;
		end
		if (rd_en_c) begin
			rdata_q <= mem[raddr_c[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			claimed_q  <= '0;
			cap_q      <= '0;
			done_q     <= 1'b0;
			idx_q      <= '0;
			k_q        <= '0;
			grown_q    <= 1'b0;
			has_next_q <= 1'b0;
			status_q   <= ffea_pkg::ST_OK;
			granted_q  <= '0;
			kind_q     <= 1'b0;
			off_q      <= '0;
			size_q     <= '0;
			nt_q       <= '0;
			prev_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			case (cmd.op)
				ffea_pkg::OP_LOAD: begin
					kind_q     <= kind;
					off_q      <= extent_offset;
					size_q     <= extent_bytes;
					idx_q      <= '0;
					grown_q    <= 1'b0;
					has_next_q <= 1'b0;
					status_q   <= ffea_pkg::ST_OK;
					granted_q  <= '0;
				end
				ffea_pkg::OP_SCAN_NEXT: begin
					prev_q <= rdata_q;
					idx_q  <= idx_q + 1'b1;
				end
				ffea_pkg::OP_MARK_NEXT: has_next_q <= 1'b1;
				ffea_pkg::OP_FIT: begin
					granted_q <= rdata_q.start;
					k_q       <= idx_q;
				end
				ffea_pkg::OP_GROW_INIT: begin
					nt_q <= (claimed_q == '0) ? ffea_pkg::FIRST_CLAIM
						: {2'b0, claimed_q, 1'b0};
				end
				ffea_pkg::OP_GROW_DBL: nt_q <= {nt_q[ffea_pkg::NT_W-2:0], 1'b0};
				ffea_pkg::OP_EXTEND: begin
					claimed_q <= nt_q[ffea_pkg::LEN_W-1:0];
					grown_q   <= 1'b1;
					idx_q     <= '0;
				end
				ffea_pkg::OP_APPEND: begin
					claimed_q <= nt_q[ffea_pkg::LEN_W-1:0];
					grown_q   <= 1'b1;
					idx_q     <= '0;
					count_q   <= count_q + 1'b1;
				end
				ffea_pkg::OP_SHIFT_UP: k_q <= k_q + 1'b1;
				ffea_pkg::OP_DEC: count_q <= count_q - 1'b1;
				ffea_pkg::OP_INS_SETUP: k_q <= count_q;
				ffea_pkg::OP_SHIFT_DN: k_q <= k_q - 1'b1;
				ffea_pkg::OP_INS_PUT: count_q <= count_q + 1'b1;
				ffea_pkg::OP_MERGE_PREV: k_q <= idx_q;
				ffea_pkg::OP_SET_STATUS: begin
					status_q  <= cmd.code;
					granted_q <= '0;
				end
				ffea_pkg::OP_DONE: done_q <= 1'b1;
				default: ;
			endcase
		end
	end

	assign done           = done_q;
	assign granted_offset = granted_q;
	assign status         = status_q;
	assign claimed_total  = claimed_q;

endmodule

// ===== hw/rtl/ffea_ctrl.sv =====
// Sequencing state machine of the extent allocator.
// Issues at most one datapath command per cycle from ffea_dp status; uses ffea_pkg.
module ffea_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  ffea_pkg::sts_t sts,
	output ffea_pkg::cmd_t cmd,
	output logic           busy
);

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISPATCH,
		S_A_SCAN,
		S_A_TEST,
		S_G_LOOP,
		S_G_TAIL,
		S_RM_LOOP,
		S_RM_WR,
		S_F_SCAN,
		S_F_TEST,
		S_F_EVAL,
		S_INS_LOOP,
		S_INS_WR,
		S_DONE
	} state_t;

	state_t state_q, state_n;

	always_comb begin
		state_n  = state_q;
		cmd.op   = ffea_pkg::OP_NONE;
		cmd.code = ffea_pkg::ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op  = ffea_pkg::OP_LOAD;
					state_n = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (!sts.kind_free) begin
					state_n = S_A_SCAN;
				end else if (sts.size_zero) begin
					state_n = S_DONE;
				end else begin
					state_n = S_F_SCAN;
				end
			end
			S_A_SCAN: begin
				if (!sts.idx_end) begin
					cmd.op  = ffea_pkg::OP_RD_IDX;
					state_n = S_A_TEST;
				end else if (sts.grown) begin
					cmd.op   = ffea_pkg::OP_SET_STATUS;
					cmd.code = ffea_pkg::ST_CAPACITY;
					state_n  = S_DONE;
				end else begin
					cmd.op  = ffea_pkg::OP_GROW_INIT;
					state_n = S_G_LOOP;
				end
			end
			S_A_TEST: begin
				if (sts.fits) begin
					cmd.op  = ffea_pkg::OP_FIT;
					state_n = sts.exact ? S_RM_LOOP : S_DONE;
				end else begin
					cmd.op  = ffea_pkg::OP_SCAN_NEXT;
					state_n = S_A_SCAN;
				end
			end
			S_G_LOOP: begin
				if (sts.grow_short) begin
					cmd.op = ffea_pkg::OP_GROW_DBL;
				end else if (sts.over_cap) begin
					cmd.op   = ffea_pkg::OP_SET_STATUS;
					cmd.code = ffea_pkg::ST_CAPACITY;
					state_n  = S_DONE;
				end else if (!sts.count_zero) begin
					cmd.op  = ffea_pkg::OP_RD_TAIL;
					state_n = S_G_TAIL;
				end else begin
					cmd.op  = ffea_pkg::OP_APPEND;
					state_n = S_A_SCAN;
				end
			end
			S_G_TAIL: begin
				if (sts.tail_adj) begin
					cmd.op  = ffea_pkg::OP_EXTEND;
					state_n = S_A_SCAN;
				end else if (sts.full) begin
					cmd.op   = ffea_pkg::OP_SET_STATUS;
					cmd.code = ffea_pkg::ST_FULL;
					state_n  = S_DONE;
				end else begin
					cmd.op  = ffea_pkg::OP_APPEND;
					state_n = S_A_SCAN;
				end
			end
			S_RM_LOOP: begin
				if (sts.k_more) begin
					cmd.op  = ffea_pkg::OP_RD_K1;
					state_n = S_RM_WR;
				end else begin
					cmd.op  = ffea_pkg::OP_DEC;
					state_n = S_DONE;
				end
			end
			S_RM_WR: begin
				cmd.op  = ffea_pkg::OP_SHIFT_UP;
				state_n = S_RM_LOOP;
			end
			S_F_SCAN: begin
				if (sts.idx_end) begin
					state_n = S_F_EVAL;
				end else begin
					cmd.op  = ffea_pkg::OP_RD_IDX;
					state_n = S_F_TEST;
				end
			end
			S_F_TEST: begin
				if (sts.gt_off) begin
					cmd.op  = ffea_pkg::OP_MARK_NEXT;
					state_n = S_F_EVAL;
				end else begin
					cmd.op  = ffea_pkg::OP_SCAN_NEXT;
					state_n = S_F_SCAN;
				end
			end
			S_F_EVAL: begin
				if (sts.ovl) begin
					cmd.op   = ffea_pkg::OP_SET_STATUS;
					cmd.code = ffea_pkg::ST_OVERLAP;
					state_n  = S_DONE;
				end else if (sts.mprev) begin
					cmd.op  = ffea_pkg::OP_MERGE_PREV;
					state_n = sts.mnext ? S_RM_LOOP : S_DONE;
				end else if (sts.mnext) begin
					cmd.op  = ffea_pkg::OP_MERGE_NEXT;
					state_n = S_DONE;
				end else if (sts.full) begin
					cmd.op   = ffea_pkg::OP_SET_STATUS;
					cmd.code = ffea_pkg::ST_FULL;
					state_n  = S_DONE;
				end else begin
					cmd.op  = ffea_pkg::OP_INS_SETUP;
					state_n = S_INS_LOOP;
				end
			end
			S_INS_LOOP: begin
				if (sts.k_above) begin
					cmd.op  = ffea_pkg::OP_RD_KM1;
					state_n = S_INS_WR;
				end else begin
					cmd.op  = ffea_pkg::OP_INS_PUT;
					state_n = S_DONE;
				end
			end
			S_INS_WR: begin
				cmd.op  = ffea_pkg::OP_SHIFT_DN;
				state_n = S_INS_LOOP;
			end
			S_DONE: begin
				cmd.op  = ffea_pkg::OP_DONE;
				state_n = S_IDLE;
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ===== hw/rtl/first_fit_extent_allocator.sv =====
// Top level of the first-fit extent allocator.
// Instantiates ffea_ctrl and ffea_dp; uses ffea_pkg.
//
// A request is taken when start is high and busy is low. Every request gives
// exactly one result, shown for a single cycle with done high; the receiver
// cannot stall it, so sample on done. The free table lives in a simple dual-port
// style memory (one read, one write per cycle) and each table access is a
// registered read followed by a use of the read data. Work per request:
//   allocate: scans entries for the first fit, moves entries up on an exact fit;
//             a growth doubles as needed, extends or appends, then rescans.
//   free:     scans entries, moves entries on insert or merge.
// A zero-size free makes no table access.
// The scan/shift loop over the memory port sets the rate. Write the capacity
// register only while busy is low.
module first_fit_extent_allocator #(
	parameter int unsigned MAX_FREE_EXTENTS = ffea_pkg::MAX_FREE_EXTENTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration: device capacity in bytes
	input  logic                       cfg_we,
	input  logic [ffea_pkg::LEN_W-1:0] cfg_wdata,
	// request
	input  logic                       start,
	output logic                       busy,
	input  logic                       kind,
	input  logic [ffea_pkg::OFF_W-1:0] extent_offset,
	input  logic [ffea_pkg::OFF_W-1:0] extent_bytes,
	// result
	output logic                       done,
	output logic [ffea_pkg::OFF_W-1:0] granted_offset,
	output logic [1:0]                 status,
	output logic [ffea_pkg::LEN_W-1:0] claimed_total
);

	ffea_pkg::cmd_t cmd;
	ffea_pkg::sts_t sts;

	// sequencer: scan, grow, shift and merge steps
	ffea_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// table memory, pointers, arithmetic, result registers
	ffea_dp #(
		.MaxExt (MAX_FREE_EXTENTS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.kind           (kind),
		.extent_offset  (extent_offset),
		.extent_bytes   (extent_bytes),
		.cmd            (cmd),
		.sts            (sts),
		.done           (done),
		.granted_offset (granted_offset),
		.status         (status),
		.claimed_total  (claimed_total)
	);

endmodule
